FILE: src/dema_pkg.sv
// Package for the double exponential moving average core.
// Holds the fixed field widths, register indexes and payload types shared by all files.
// Depends on nothing.
package dema_pkg;
	localparam int SAMPLE_W = 32;
	localparam int PERIOD_W = 16;
	localparam int ALPHA_W = 17;
	localparam int AVG_W = 48;
	localparam int COUNT_W = 18;
	localparam int DIFF_W = AVG_W + 1;
	localparam int ACC_W = AVG_W + ALPHA_W + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_ALPHA = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [AVG_W-1:0] avg_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ACC_W-1:0] acc_t;
endpackage

FILE: src/dema_if.sv
// Valid/ready channels of the double exponential moving average core.
// Uses dema_pkg for the payload types.
interface dema_in_if import dema_pkg::*; ();
	logic valid;
	logic ready;
	sample_t sample;
	logic first_of_series;

	modport source (output valid, output sample, output first_of_series, input ready);
	modport sink (input valid, input sample, input first_of_series, output ready);
endinterface

interface dema_out_if import dema_pkg::*; ();
	logic valid;
	logic ready;
	sample_t dema_value;

	modport source (output valid, output dema_value, input ready);
	modport sink (input valid, input dema_value, output ready);
endinterface

FILE: src/dema_blend_unit.sv
// Shared blend unit: a + (v - a) * w, rounded half up from Q16.48 to Q16.32.
// Steps in order: difference and product are registered, the accumulate is combinational. Uses dema_pkg.
module dema_blend_unit import dema_pkg::*; (
	input  logic                clk,
	input  avg_t                a,
	input  avg_t                v,
	input  logic [ALPHA_W-1:0]  w,
	output avg_t                result
);
	diff_t diff_s1;
	acc_t prod_s2;
	acc_t acc;
	logic signed [DIFF_W+ALPHA_W:0] prod;

	assign prod = diff_s1 * $signed({1'b0, w});

	always_ff @(posedge clk) begin
		diff_s1 <= DIFF_W'(v) - DIFF_W'(a);
		prod_s2 <= prod[ACC_W-1:0];
	end

	always_comb begin
		acc = {{(ACC_W-AVG_W-FRAC_SHIFT){a[AVG_W-1]}}, a, {FRAC_SHIFT{1'b0}}}
			+ prod_s2 + ACC_W'(32768);
		result = acc[AVG_W+FRAC_SHIFT-1:FRAC_SHIFT];
	end
endmodule

FILE: src/double_exponential_moving_average_core.sv
// Double exponential moving average core: top level with sequencer and register port.
// Uses dema_pkg, dema_in_if / dema_out_if and dema_blend_unit.
//
// Samples arrive on feed (sample, first_of_series), results leave on result
// (dema_value), both valid/ready; an item moves when valid and ready are high.
// period and alpha are written over the APB port at byte addresses 0 and 4; the user
// writes them only while idle and sets alpha to 2/(period+1) in unsigned Q1.16, as the
// block enforces neither (alpha above one is clamped). Each sample runs through one
// shared blend unit (subtract, multiply, add): after the accept cycle the sequencer steps
// DIFF1, MUL1, ACC1 for the first average; from count max(period-1,0) on it also
// steps DIFF2, MUL2, ACC2 for the second, and from twice that count it enters OUT.
// feed.ready is high only in idle, so a new sample waits until the last is done.
// A result sits in an output register; the next sample is accepted while it
// waits, and the sequencer holds in its last step only if a second result is
// ready before the first is taken. Reset clears both averages, the sample
// count and the output valid, and restores period 1 and alpha one.
module double_exponential_moving_average_core import dema_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	dema_in_if.sink             feed,
	dema_out_if.source          result
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF1 = 3'd1;
	localparam logic [2:0] ST_MUL1  = 3'd2;
	localparam logic [2:0] ST_ACC1  = 3'd3;
	localparam logic [2:0] ST_DIFF2 = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_ACC2  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [PERIOD_W-1:0] period_q;
	logic [ALPHA_W-1:0] alpha_q;
	avg_t first_avg_q;
	avg_t second_avg_q;
	logic [COUNT_W-1:0] count_q;
	avg_t xs_q;
	logic [ALPHA_W-1:0] w_q;
	logic [COUNT_W-1:0] seed_at_q;
	logic [COUNT_W-1:0] out_at_q;
	logic out_valid_q;
	sample_t out_data_q;

	logic cfg_wr;
	logic accept;
	logic seeding;
	logic phase2;
	logic slot_free;
	avg_t unit_a;
	avg_t unit_v;
	avg_t unit_res;
	logic [COUNT_W-1:0] count_inc;
	logic [PERIOD_W-1:0] seed_at;
	logic signed [AVG_W+1:0] dval;
	logic signed [AVG_W+1-FRAC_SHIFT:0] rval;
	sample_t sat_val;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_ALPHA) ? PDATA_W'(alpha_q) : PDATA_W'(period_q);

	assign feed.ready = (state_q == ST_IDLE);
	assign accept = feed.valid & feed.ready;
	assign result.valid = out_valid_q;
	assign result.dema_value = out_data_q;

	assign seed_at = (period_q == '0) ? '0 : period_q - PERIOD_W'(1);
	assign seeding = (count_q == seed_at_q);
	assign phase2 = (state_q == ST_DIFF2) || (state_q == ST_MUL2) || (state_q == ST_ACC2);
	assign unit_v = phase2 ? first_avg_q : xs_q;
	assign unit_a = (phase2 && !((state_q == ST_DIFF2) && seeding)) ? second_avg_q
		: first_avg_q;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
	assign slot_free = !out_valid_q || result.ready;

	always_comb begin
		dval = ((AVG_W+2)'(first_avg_q) <<< 1) - (AVG_W+2)'(second_avg_q)
			+ (AVG_W+2)'(32768);
		rval = dval[AVG_W+1:FRAC_SHIFT];
		if (rval[AVG_W+1-FRAC_SHIFT:SAMPLE_W-1] == '0
			|| rval[AVG_W+1-FRAC_SHIFT:SAMPLE_W-1] == '1) begin
			sat_val = rval[SAMPLE_W-1:0];
		end else if (rval[AVG_W+1-FRAC_SHIFT]) begin
			sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	dema_blend_unit u_blend (
		.clk    (clk),
		.a      (unit_a),
		.v      (unit_v),
		.w      (w_q),
		.result (unit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(1);
			alpha_q <= ALPHA_ONE;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
				REG_ALPHA: alpha_q <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q <= {{(AVG_W-SAMPLE_W-FRAC_SHIFT){feed.sample[SAMPLE_W-1]}},
				feed.sample, {FRAC_SHIFT{1'b0}}};
			w_q <= (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
			seed_at_q <= COUNT_W'(seed_at);
			out_at_q <= COUNT_W'(seed_at) << 1;
		end
		if (state_q == ST_OUT && slot_free) begin
			out_data_q <= sat_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_avg_q <= '0;
			second_avg_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (feed.first_of_series) begin
							first_avg_q <= {{(AVG_W-SAMPLE_W-FRAC_SHIFT){feed.sample[SAMPLE_W-1]}},
								feed.sample, {FRAC_SHIFT{1'b0}}};
							count_q <= '0;
						end
						state_q <= ST_DIFF1;
					end
				end
				ST_DIFF1: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_ACC1;
				ST_ACC1: begin
					first_avg_q <= unit_res;
					if (count_q >= seed_at_q) begin
						state_q <= ST_DIFF2;
					end else begin
						count_q <= count_inc;
						state_q <= ST_IDLE;
					end
				end
				ST_DIFF2: begin
					if (seeding) begin
						second_avg_q <= first_avg_q;
					end
					state_q <= ST_MUL2;
				end
				ST_MUL2: state_q <= ST_ACC2;
				ST_ACC2: begin
					second_avg_q <= unit_res;
					if (count_q >= out_at_q) begin
						state_q <= ST_OUT;
					end else begin
						count_q <= count_inc;
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						count_q <= count_inc;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: test/tb.sv
// Testbench for double_exponential_moving_average_core: directed and random Q16.16 sample
// streams checked item by item against a cycle-free shadow of both averages and the count.
// Depends on dema_pkg, dema_in_if / dema_out_if and the core RTL.
module tb import dema_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam logic signed [AVG_W+1:0] DEMA_MAX = 50'sd2147483647;
	localparam logic signed [AVG_W+1:0] DEMA_MIN = -50'sd2147483648;
	localparam logic [PDATA_W-1:0] ALPHA_ALL = PDATA_W'({ALPHA_W{1'b1}});

	class dema_shadow;
		logic [PERIOD_W-1:0] period;
		logic [ALPHA_W-1:0] alpha;
		avg_t avg_fast;
		avg_t avg_slow;
		logic [COUNT_W-1:0] count;
		sample_t due[$];
		int unsigned errors;

		function new();
			period = PERIOD_W'(1);
			alpha = ALPHA_ONE;
			avg_fast = '0;
			avg_slow = '0;
			count = '0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_PERIOD: period = value[PERIOD_W-1:0];
				REG_ALPHA: alpha = value[ALPHA_W-1:0];
			endcase
		endfunction

		function avg_t blend(avg_t a, avg_t v, logic [ALPHA_W-1:0] w);
			acc_t sa, sv, sw, acc;
			sa = a;
			sv = v;
			sw = {{(ACC_W-ALPHA_W){1'b0}}, w};
			acc = sa * (acc_t'(ALPHA_ONE) - sw) + sv * sw;
			acc = (acc + acc_t'(32768)) >>> FRAC_SHIFT;
			return acc[AVG_W-1:0];
		endfunction

		function void take_sample(sample_t s, logic mark);
			avg_t xs;
			logic [ALPHA_W-1:0] w;
			int unsigned seed_at, out_at;
			logic signed [AVG_W+1:0] d, r;
			xs = {s, 16'h0000};
			w = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
			seed_at = (period == 0) ? 0 : period - 1;
			out_at = 2 * seed_at;
			if (mark) begin
				avg_fast = xs;
				count = '0;
			end
			avg_fast = blend(avg_fast, xs, w);
			if (count == seed_at)
				avg_slow = avg_fast;
			if (count >= seed_at) begin
				avg_slow = blend(avg_slow, avg_fast, w);
				if (count >= out_at) begin
					d = avg_fast;
					d = (d <<< 1) - avg_slow;
					r = (d + 50'sd32768) >>> FRAC_SHIFT;
					if (r > DEMA_MAX)
						r = DEMA_MAX;
					else if (r < DEMA_MIN)
						r = DEMA_MIN;
					due.push_back(r[SAMPLE_W-1:0]);
				end
			end
			if (count != COUNT_MAX)
				count++;
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 100)
				$display("mismatch: %s", what);
		endtask

		task match_result(sample_t got);
			sample_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("dema_value %h with no item pending", got));
				return;
			end
			want = due.pop_front();
			if (got !== want)
				report_mismatch($sformatf("dema_value %h, want %h", got, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned quiet_cycles;
	sample_t level;
	dema_shadow shadow = new();

	dema_in_if feed_ch();
	dema_out_if result_ch();

	double_exponential_moving_average_core uut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.feed(feed_ch),
		.result(result_ch)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// check the older result before noting the new item
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			shadow.match_result(result_ch.dema_value);
		if (arst_n && feed_ch.valid && feed_ch.ready)
			shadow.take_sample(feed_ch.sample, feed_ch.first_of_series);
	end

	always @(posedge clk) begin
		if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[double_exponential_moving_average_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic push_sample(input sample_t s, input logic mark);
		while ($urandom_range(99) < src_idle_pct) begin
			feed_ch.valid <= 1'b0;
			@(posedge clk);
		end
		feed_ch.valid <= 1'b1;
		feed_ch.sample <= s;
		feed_ch.first_of_series <= mark;
		do @(posedge clk); while (!feed_ch.ready);
	endtask

	// drop valid, drain pending results, then let a sample without output finish
	task automatic settle();
		feed_ch.valid <= 1'b0;
		@(posedge clk);
		while (shadow.due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return sample_t'($urandom);
			1: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: begin
				level = level + sample_t'($urandom_range(32'h0010_0000)) - sample_t'(32'h0008_0000);
				return level;
			end
		endcase
	endfunction

	task automatic run_phase(input int unsigned items, input bit keep_series);
		int unsigned left;
		logic mark;
		left = 0;
		for (int unsigned i = 0; i < items; i++) begin
			if (left == 0) begin
				left = $urandom_range(3 * shadow.period + 20, 1);
				mark = !(i == 0 && keep_series);
				if ($urandom_range(3) == 0)
					level = sample_t'($urandom);
			end else begin
				mark = ($urandom_range(29) == 0);
			end
			left--;
			push_sample(pick_sample(), mark);
		end
	endtask

	initial begin
		logic [PDATA_W-1:0] p, a;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		feed_ch.valid = 1'b0;
		feed_ch.sample = '0;
		feed_ch.first_of_series = 1'b0;
		result_ch.ready = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		quiet_cycles = 0;
		level = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, series begun without a mark
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h0000_0000, 1'b0);
		push_sample(32'hffff_ffff, 1'b1);
		push_sample(32'h0000_0001, 1'b0);
		settle();

		// period zero, alpha above one
		reg_write(REG_PERIOD, '0);
		reg_write(REG_ALPHA, ALPHA_ALL);
		push_sample(32'h1234_5678, 1'b1);
		push_sample(32'hedcb_a987, 1'b0);
		settle();

		// step up then down to drive the output into both rails
		reg_write(REG_PERIOD, 2);
		reg_write(REG_ALPHA, 32768);
		push_sample(32'h8000_0000, 1'b1);
		repeat (4) push_sample(32'h7fff_ffff, 1'b0);
		repeat (3) push_sample(32'h8000_0000, 1'b0);
		settle();

		// alpha zero: blends leave both averages as they are after the mark and the seed
		reg_write(REG_ALPHA, 0);
		push_sample(32'h0001_8000, 1'b1);
		push_sample(32'hffff_0000, 1'b0);
		push_sample(32'h0005_0000, 1'b0);
		settle();

		for (int k = 0; k < 12; k++) begin
			p = $urandom_range(16, 1);
			a = (131072 + (p + 1) / 2) / (p + 1);
			if ($urandom_range(2) == 0)
				a = $urandom_range(ALPHA_ONE, 0);
			case (k)
				3: begin
					p = 65535;
					a = 2;
				end
				4: begin
					p = 4;
					a = 26214;
				end
				6: begin
					p = 0;
					a = $urandom_range(ALPHA_ALL, 0);
				end
				8: a = $urandom_range(ALPHA_ALL, ALPHA_ONE + 1);
				9: a = 0;
				10: begin
					p = 1;
					a = ALPHA_ONE;
				end
				default: ;
			endcase
			reg_write(REG_PERIOD, p);
			reg_write(REG_ALPHA, a);
			case (k % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 45;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 45;
				end
				default: begin
					src_idle_pct = 8;
					sink_stall_pct = 8;
				end
			endcase
			run_phase((k == 3) ? 40 : 120, (k == 4) || ($urandom_range(3) == 0));
			settle();
		end

		if (shadow.errors == 0)
			$display("[double_exponential_moving_average_core] OK");
		else
			$display("[double_exponential_moving_average_core] ERROR");
		$finish;
	end
endmodule
